### hdl/rdse_pkg.sv
// ----------------------------------------------------------------------------
// rdse_pkg
// Types, register indexes and microcode for the radix digit string encoder.
// ----------------------------------------------------------------------------
package rdse_pkg;

   localparam int DIGIT_BITS = 4;
   localparam int RADIX_BITS = 5;
   localparam int CHAR_BITS  = 8;
   localparam int MAP_BITS   = 64;
   localparam int CSR_IDX_BITS = 2;
   localparam int CHUNK_BITS = 8;

   localparam logic [CHAR_BITS-1:0] MINUS_SIGN = 8'h2D;

   localparam logic [CSR_IDX_BITS-1:0] CSR_RADIX    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAP_LOW  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAP_HIGH = 2'd2;

   localparam logic [RADIX_BITS-1:0] RADIX_RESET = 5'd10;
   localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 5'd2;

   typedef enum logic [2:0] {
      S_IDLE     = 3'd0,
      S_DIV      = 3'd1,
      S_STORE    = 3'd2,
      S_SIGN     = 3'd3,
      S_SIGN_OUT = 3'd4,
      S_READ     = 3'd5,
      S_EMIT     = 3'd6,
      S_LOOP     = 3'd7
   } step_type;

   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_LOAD  = 3'd1,
      OP_DIV   = 3'd2,
      OP_STORE = 3'd3,
      OP_SIGN  = 3'd4,
      OP_READ  = 3'd5,
      OP_DIGIT = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      C_NO_ACCEPT   = 3'd0,
      C_CHUNK_MORE  = 3'd1,
      C_MORE_DIGITS = 3'd2,
      C_NO_SIGN     = 3'd3,
      C_OUT_BUSY    = 3'd4,
      C_COUNT_NZ    = 3'd5
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   // Jump to target when cond holds, else fall through to the next step.
   // The last step falls through to step zero.
   function automatic ctrl_word_type ucode(input step_type step);
      ctrl_word_type w;
      unique case (step)
         S_IDLE:     w = '{OP_LOAD,  C_NO_ACCEPT,   S_IDLE};
         S_DIV:      w = '{OP_DIV,   C_CHUNK_MORE,  S_DIV};
         S_STORE:    w = '{OP_STORE, C_MORE_DIGITS, S_DIV};
         S_SIGN:     w = '{OP_NONE,  C_NO_SIGN,     S_READ};
         S_SIGN_OUT: w = '{OP_SIGN,  C_OUT_BUSY,    S_SIGN_OUT};
         S_READ:     w = '{OP_READ,  C_OUT_BUSY,    S_READ};
         S_EMIT:     w = '{OP_DIGIT, C_OUT_BUSY,    S_EMIT};
         S_LOOP:     w = '{OP_NONE,  C_COUNT_NZ,    S_READ};
      endcase
      return w;
   endfunction

   function automatic logic [CHAR_BITS-1:0] symbol_of(
      input logic [MAP_BITS-1:0]   map_low,
      input logic [MAP_BITS-1:0]   map_high,
      input logic [DIGIT_BITS-1:0] digit
   );
      logic [MAP_BITS-1:0] map;
      map = digit[3] ? map_high : map_low;
      return map[{digit[2:0], 3'b000} +: CHAR_BITS];
   endfunction

endpackage

### hdl/radix_digit_string_encoder.sv
// ----------------------------------------------------------------------------
// radix_digit_string_encoder
// Writes an unsigned value as characters in a programmable radix, sign first.
// ----------------------------------------------------------------------------
//  channel  handshake          payload
//  req      valid / stall      magnitude, negative
//  rsp      valid / stall      character, last
//  csr      valid / ready      index, data
//
//  One item at a time, driven by an 8-step microcode table. Each digit is
//  found by long division (8 quotient bits per cycle) and stored, and each
//  digit character is read back from the buffer and emitted. The final
//  character may wait in the output register while the next item is taken.
//  rsp stall holds the send steps. Reset is synchronous and needs no
//  clearing pass.
// ----------------------------------------------------------------------------
module radix_digit_string_encoder #(
   parameter int MAX_RADIX  = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [VALUE_BITS-1:0]               req_magnitude,
   input  logic                                req_negative,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rdse_pkg::CHAR_BITS-1:0]      rsp_character,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rdse_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [rdse_pkg::MAP_BITS-1:0]       csr_data
);
   import rdse_pkg::*;

   localparam int CHUNKS  = (VALUE_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
   localparam int WORD_W  = CHUNKS * CHUNK_BITS;
   localparam int CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
   localparam int IDX_W   = $clog2(VALUE_BITS);
   localparam int CNT_W   = $clog2(VALUE_BITS + 1);
   localparam logic [CHUNK_W-1:0]    CHUNK_LAST = CHUNK_W'(CHUNKS - 1);
   localparam logic [CNT_W-1:0]      CNT_TOP    = CNT_W'(VALUE_BITS - 1);
   localparam logic [RADIX_BITS-1:0] RADIX_MAX  = RADIX_BITS'(MAX_RADIX);

   step_type                pc_ff, pc_in;
   logic [WORD_W-1:0]       value_ff, value_in;
   logic [DIGIT_BITS-1:0]   rem_ff, rem_in;
   logic [CHUNK_W-1:0]      chunk_ff, chunk_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    sign_ff, sign_in;
   logic [DIGIT_BITS-1:0]   rd_digit_ff;
   logic                    out_valid_ff, out_valid_in;
   logic [CHAR_BITS-1:0]    out_char_ff, out_char_in;
   logic                    out_last_ff, out_last_in;
   logic [RADIX_BITS-1:0]   radix_ff;
   logic [MAP_BITS-1:0]     map_low_ff, map_high_ff;
   logic [DIGIT_BITS-1:0]   digit_mem [VALUE_BITS];

   ctrl_word_type           ctrl;
   logic                    accept;
   logic                    out_free;
   logic                    cond_hit;
   logic                    mem_we, mem_re;
   logic [CNT_W-1:0]        count_dec;
   logic [RADIX_BITS-1:0]   radix_eff;
   logic [CHUNK_BITS-1:0]   q_bits;
   logic [DIGIT_BITS-1:0]   q_rem;

   assign csr_ready     = 1'b1;
   assign req_stall     = (pc_ff != S_IDLE);
   assign accept        = req_valid && !req_stall;
   assign out_free      = !out_valid_ff || !rsp_stall;
   assign rsp_valid     = out_valid_ff;
   assign rsp_character = out_char_ff;
   assign rsp_last      = out_last_ff;
   assign count_dec     = count_ff - 1'b1;
   assign ctrl          = ucode(pc_ff);

   always_comb begin
      if (radix_ff < RADIX_MIN)
         radix_eff = RADIX_MIN;
      else if (radix_ff > RADIX_MAX)
         radix_eff = RADIX_MAX;
      else
         radix_eff = radix_ff;
   end

   // One long-division chunk: 8 quotient bits, remainder stays below radix.
   always_comb begin
      logic [DIGIT_BITS:0] t;
      logic [DIGIT_BITS-1:0] r;
      logic [CHUNK_BITS-1:0] top;
      r   = rem_ff;
      top = value_ff[WORD_W-1 -: CHUNK_BITS];
      q_bits = '0;
      for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
         t = {r, top[i]};
         if (t >= radix_eff) begin
            q_bits[i] = 1'b1;
            t = t - radix_eff;
         end
         r = t[DIGIT_BITS-1:0];
      end
      q_rem = r;
   end

   // Next step
   always_comb begin
      unique case (ctrl.cond)
         C_NO_ACCEPT:   cond_hit = !accept;
         C_CHUNK_MORE:  cond_hit = (chunk_ff != CHUNK_LAST);
         C_MORE_DIGITS: cond_hit = (value_ff != '0) && (count_ff < CNT_TOP);
         C_NO_SIGN:     cond_hit = !sign_ff;
         C_OUT_BUSY:    cond_hit = !out_free && (ctrl.op != OP_READ);
         C_COUNT_NZ:    cond_hit = (count_ff != '0);
         default:       cond_hit = 1'b0;
      endcase
      pc_in = cond_hit ? ctrl.target : step_type'(pc_ff + 3'd1);
   end

   // Datapath control
   always_comb begin
      value_in     = value_ff;
      rem_in       = rem_ff;
      chunk_in     = chunk_ff;
      count_in     = count_ff;
      sign_in      = sign_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      unique case (ctrl.op)
         OP_NONE: ;
         OP_LOAD: begin
            if (accept) begin
               value_in = WORD_W'(req_magnitude);
               sign_in  = req_negative;
               rem_in   = '0;
               chunk_in = '0;
               count_in = '0;
            end
         end
         OP_DIV: begin
            value_in = (value_ff << CHUNK_BITS) | WORD_W'(q_bits);
            rem_in   = q_rem;
            chunk_in = (chunk_ff == CHUNK_LAST) ? '0 : chunk_ff + 1'b1;
         end
         OP_STORE: begin
            mem_we   = 1'b1;
            count_in = count_ff + 1'b1;
            rem_in   = '0;
         end
         OP_SIGN: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = MINUS_SIGN;
               out_last_in  = 1'b0;
               sign_in      = 1'b0;
            end
         end
         OP_READ: begin
            mem_re   = 1'b1;
            count_in = count_dec;
         end
         OP_DIGIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = symbol_of(map_low_ff, map_high_ff, rd_digit_ff);
               out_last_in  = (count_ff == '0);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= S_IDLE;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
         sign_ff      <= 1'b0;
         chunk_ff     <= '0;
         rem_ff       <= '0;
         value_ff     <= '0;
      end else begin
         pc_ff        <= pc_in;
         out_valid_ff <= out_valid_in;
         count_ff     <= count_in;
         sign_ff      <= sign_in;
         chunk_ff     <= chunk_in;
         rem_ff       <= rem_in;
         value_ff     <= value_in;
      end
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff    <= RADIX_RESET;
         map_low_ff  <= '0;
         map_high_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RADIX:    radix_ff    <= csr_data[RADIX_BITS-1:0];
            CSR_MAP_LOW:  map_low_ff  <= csr_data;
            CSR_MAP_HIGH: map_high_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // digit buffer
   always_ff @(posedge clock) begin
      if (mem_we)
         digit_mem[count_ff[IDX_W-1:0]] <= rem_ff;
      if (mem_re)
         rd_digit_ff <= digit_mem[count_dec[IDX_W-1:0]];
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(VALUE_BITS))
      else $error("digit count beyond buffer depth");

   a_rem_below_radix: assert property (@(posedge clock) disable iff (reset)
      {1'b0, rem_ff} < radix_eff)
      else $error("remainder not below radix");

   a_read_nonempty: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == S_READ) |-> (count_ff != '0))
      else $error("buffer read with no digit left");

   a_accept_divides: assert property (@(posedge clock) disable iff (reset)
      accept |=> (pc_ff == S_DIV) && (chunk_ff == '0))
      else $error("accepted item did not start division");

   a_store_room: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == S_STORE) |-> (count_ff < CNT_W'(VALUE_BITS)))
      else $error("digit store past buffer end");

endmodule
